>>> rtl/pbse_pkg.sv
// Shared types, command codes and result codes for the postfix boolean stack evaluator.
package pbse_pkg;

    localparam int STACK_DEPTH_DEF = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam logic [2:0] CMD_PUSH = 3'd0;
    localparam logic [2:0] CMD_GT   = 3'd1;
    localparam logic [2:0] CMD_LT   = 3'd2;
    localparam logic [2:0] CMD_EQ   = 3'd3;
    localparam logic [2:0] CMD_OR   = 3'd4;
    localparam logic [2:0] CMD_AND  = 3'd5;
    localparam logic [2:0] CMD_END  = 3'd6;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;
    localparam logic [1:0] STATUS_PENDING   = 2'd3;

    localparam logic [1:0] VERDICT_FALSE   = 2'd0;
    localparam logic [1:0] VERDICT_TRUE    = 2'd1;
    localparam logic [1:0] VERDICT_UNKNOWN = 2'd2;
    localparam logic [1:0] VERDICT_NONE    = 2'd3;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] top_value;
        logic [4:0]  stack_depth;
        logic [1:0]  verdict;
    } t_out_item;

endpackage

>>> rtl/postfix_boolean_stack_evaluator_unit.sv
// Top level of the postfix boolean stack evaluator: control, top-of-stack cache and result register.
// An accepted item is held in the item registers; its result item is registered when it commits.
// The input stalls while an item executes, since the entry below the top comes from the registered
// read of the stack RAM; a stalled result holds the next item in its execute state.
// Reset (synchronous, active low) empties the stack, clears the error flag and drops any waiting
// result. The stack RAM is not cleared: only entries below the fill count are ever used.
module postfix_boolean_stack_evaluator_unit #(
    parameter int STACK_DEPTH = pbse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = pbse_pkg::VALUE_WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pbse_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pbse_pkg::t_out_item o_out_item
);

    // Fill count must hold STACK_DEPTH itself; the address only needs to index the entries.
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    // Common width for moving between the 16-bit item fields and the stored values.
    localparam int WW = (VALUE_WIDTH > 16) ? VALUE_WIDTH : 16;

    // Two-state sequencer: accept an item, then execute it once the read data is back.
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                   r_state;
    logic                   n_state;
    logic [2:0]             r_cmd;
    logic [VALUE_WIDTH-1:0] r_pv;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_err;
    logic                   n_err;
    // The top entry is cached in a register, so only the entry below it comes from the RAM.
    logic [VALUE_WIDTH-1:0] r_top;
    logic [VALUE_WIDTH-1:0] n_top;
    logic                   r_out_valid;
    pbse_pkg::t_out_item    r_out_item;

    logic                   w_accept;
    logic                   w_commit;
    logic [WW-1:0]          w_pv_wide;
    logic [WW-1:0]          w_top_wide;
    logic [CW-1:0]          w_below_cnt;
    logic [VALUE_WIDTH-1:0] w_below;
    logic                   w_res;
    logic [1:0]             w_status;
    logic [1:0]             w_verdict;
    logic                   w_wr_req;
    logic [AW-1:0]          w_wr_addr;
    logic [VALUE_WIDTH-1:0] w_wr_data;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    // The execute cycle completes only when the result register is free or being emptied.
    assign w_commit   = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);

    assign w_pv_wide  = WW'(i_in_item.push_value);

    // The RAM is read every cycle at the entry below the top. Writes happen only at the commit
    // edge, and the idle state always comes before the next item executes, so the read data
    // seen in the execute state always reflects the latest write without forwarding.
    assign w_below_cnt = r_count - CW'(2);

    pbse_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_req && w_commit),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_below_cnt[AW-1:0]),
        .o_rd_data (w_below)
    );

    // Operator result: the top entry is compared with, or combined with, the entry below it.
    always_comb begin
        case (r_cmd) inside
            pbse_pkg::CMD_GT: w_res = (r_top > w_below);
            pbse_pkg::CMD_LT: w_res = (r_top < w_below);
            pbse_pkg::CMD_EQ: w_res = (r_top == w_below);
            pbse_pkg::CMD_OR: w_res = (r_top != '0) || (w_below != '0);
            default:          w_res = (r_top != '0) && (w_below != '0);
        endcase
    end

    // Effect of the item in the execute state on the count, the error flag and the stack.
    always_comb begin
        n_count   = r_count;
        n_err     = r_err;
        n_top     = r_top;
        w_status  = pbse_pkg::STATUS_OK;
        w_verdict = pbse_pkg::VERDICT_NONE;
        w_wr_req  = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr_data = r_pv;
        if (r_cmd == pbse_pkg::CMD_END) begin
            // An end item reports on the top entry and then empties the stack.
            if (r_err) begin
                w_status  = pbse_pkg::STATUS_PENDING;
                w_verdict = pbse_pkg::VERDICT_UNKNOWN;
            end else if (r_count == '0) begin
                w_verdict = pbse_pkg::VERDICT_UNKNOWN;
            end else if (r_top == '0) begin
                w_verdict = pbse_pkg::VERDICT_FALSE;
            end else if (r_top == VALUE_WIDTH'(1)) begin
                w_verdict = pbse_pkg::VERDICT_TRUE;
            end else begin
                w_verdict = pbse_pkg::VERDICT_UNKNOWN;
            end
            n_count = '0;
            n_err   = 1'b0;
            n_top   = '0;
        end else if (r_err) begin
            // With an error pending the stack is frozen until the next end item.
            w_status = pbse_pkg::STATUS_PENDING;
        end else begin
            unique case (r_cmd) inside
                pbse_pkg::CMD_PUSH: begin
                    if (r_count >= CW'(STACK_DEPTH)) begin
                        w_status = pbse_pkg::STATUS_OVERFLOW;
                        n_err    = 1'b1;
                    end else begin
                        w_wr_req = 1'b1;
                        n_count  = r_count + CW'(1);
                        n_top    = r_pv;
                    end
                end
                pbse_pkg::CMD_GT, pbse_pkg::CMD_LT, pbse_pkg::CMD_EQ,
                pbse_pkg::CMD_OR, pbse_pkg::CMD_AND: begin
                    if (r_count < CW'(2)) begin
                        w_status = pbse_pkg::STATUS_UNDERFLOW;
                        n_err    = 1'b1;
                    end else begin
                        // Two entries are popped and the result is written where the lower one sat.
                        w_wr_req  = 1'b1;
                        w_wr_addr = w_below_cnt[AW-1:0];
                        w_wr_data = VALUE_WIDTH'(w_res);
                        n_count   = r_count - CW'(1);
                        n_top     = VALUE_WIDTH'(w_res);
                    end
                end
                default: begin
                    // The unused code leaves everything as it is.
                end
            endcase
        end
    end

    assign w_top_wide = WW'(n_top);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_err       <= 1'b0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_commit) begin
                r_count     <= n_count;
                r_err       <= n_err;
                r_top       <= n_top;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_item.cmd;
            r_pv  <= w_pv_wide[VALUE_WIDTH-1:0];
        end
        if (w_commit) begin
            r_out_item.status      <= w_status;
            r_out_item.top_value   <= w_top_wide[15:0];
            r_out_item.stack_depth <= 5'(n_count);
            r_out_item.verdict     <= w_verdict;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

>>> rtl/pbse_stack_ram.sv
// Single-port-write, single-port-read stack memory with a registered read.
module pbse_stack_ram #(
    parameter int DEPTH = pbse_pkg::STACK_DEPTH_DEF,
    parameter int WIDTH = pbse_pkg::VALUE_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
